[rtl/mnsf_pkg.sv]
// Package for the moving notch slope filter core: field widths, coefficient formats
// and stream packing constants. Used by the core and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mnsf_pkg;

    localparam int INST_W        = 3;              // instance count must be a power of two
    localparam int NUM_INSTANCES = 1 << INST_W;

    localparam int TS_W  = 24;                     // time step, Q0.24
    localparam int CF_W  = 24;                     // corner frequency, Q8.16
    localparam int SMP_W = 32;                     // samples, Q16.16

    localparam int X_W   = 32;                     // x, Q8.24
    localparam int S_W   = 48;                     // x^2, Q16.32
    localparam int K_W   = 48;                     // 0.7 x^2
    localparam int D_W   = 41;                     // 2x in Q.32
    localparam int CO_W  = 51;                     // signed negated feedback coefficients
    localparam int A2_W  = 50;                     // divisor a2
    localparam int B_W   = SMP_W + 1;              // sample difference / history operand
    localparam int LO_W  = 26;                     // low slice of a coefficient per product
    localparam int ACC_W = 88;                     // numerator accumulator

    localparam int DV_W  = 56;                     // 7*s padded to whole bytes
    localparam int DV_BYTES = DV_W / 8;

    localparam int HIST_W = 3 * SMP_W;             // {y2, y1, u1}

    localparam logic [A2_W-1:0] C28       = 50'd12025908428;   // floor(2.8 * 2^32)
    localparam logic [12:0]     RECIP10   = 13'd6554;          // ceil(2^16 / 10)
    localparam logic [3:0]      TEN       = 4'd10;
    localparam logic [TS_W-1:0] TS_RESET  = 24'd167772;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_INIT = 1'b1;

    localparam logic [SMP_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [SMP_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage
`default_nettype wire

[rtl/mnsf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mnsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/moving_notch_slope_filter_core.sv]
// Bank of eight second-order slope filters (bilinear, damping 0.7), history kept in one RAM.
// Depends on mnsf_pkg and mnsf_ram.
//
// One item is in work at a time; from acceptance to a valid result it passes through a RAM
// read alongside the x product, the x^2 product, the byte-wise divide of 7*x^2 by ten, the
// coefficients, the numerator on the shared 27x33 multiplier, sign and range, the
// two-bit-per-cycle divider by a2 and the loading of the output register. s_tready is high
// only while the core is idle, so a new item is accepted only once the last one has been loaded;
// a result waits in the output register, and the next item may be accepted while it does. A
// result still waiting when the next one is ready holds the core in its last step. History
// reads as zero after reset until an instance is first written.
// cfg_wdata is the time step and must only be written while idle.
`timescale 1ns / 1ps
`default_nettype none
module moving_notch_slope_filter_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mnsf_pkg::TS_W-1:0]      cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [2:0] instance_index, [34:3] sample_in, [58:35] corner_freq, rest zero
    input  wire logic [mnsf_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] kind
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] sample_out
    output logic [mnsf_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] saturated
    output logic                                m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_SQUARE, ST_DIV10, ST_COEF,
        ST_MAC, ST_ABS, ST_RANGE, ST_DIV, ST_DONE
    } state_t;

    localparam int AW = mnsf_pkg::INST_W;
    localparam int SW = mnsf_pkg::SMP_W;

    state_t state_reg;
    logic [3:0] cnt_reg;
    logic [mnsf_pkg::TS_W-1:0] ts_reg;
    logic [mnsf_pkg::NUM_INSTANCES-1:0] valid_reg;

    logic          kind_reg;
    logic [AW-1:0] idx_reg;
    logic [SW-1:0] u_reg, u1_reg, y1_reg, y2_reg;
    logic [mnsf_pkg::CF_W-1:0] cf_reg;

    logic [mnsf_pkg::X_W-1:0]  x_reg;
    logic [mnsf_pkg::DV_W-1:0] dsh_reg, kacc_reg;
    logic [3:0]                r10_reg;
    logic [mnsf_pkg::A2_W-1:0] a2_reg;
    logic signed [mnsf_pkg::CO_W-1:0] d_reg, na1_reg, na0_reg;
    logic signed [mnsf_pkg::ACC_W-1:0] acc_reg;
    logic          neg_reg, big_reg;
    logic [mnsf_pkg::ACC_W-1:0] mag_reg;
    logic [mnsf_pkg::A2_W-1:0]  rem_reg;
    logic [SW-1:0] qlo_reg, q_reg;

    logic          m_tvalid_reg, m_tuser_reg;
    logic [SW-1:0] m_tdata_reg;

    // history RAM
    logic [AW-1:0] ram_raddr;
    logic          ram_we;
    logic [mnsf_pkg::HIST_W-1:0] ram_wdata, ram_rdata;

    logic accept;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign ram_raddr = (state_reg == ST_IDLE) ? s_tdata[AW-1:0] : idx_reg;

    mnsf_ram #(
        .WIDTH (mnsf_pkg::HIST_W),
        .DEPTH (mnsf_pkg::NUM_INSTANCES)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // history, zero until written; an initialise item seeds all three with the sample
    logic [mnsf_pkg::HIST_W-1:0] hist;
    always_comb begin
        hist = valid_reg[idx_reg] ? ram_rdata : '0;
        if (kind_reg == mnsf_pkg::KIND_INIT) begin
            hist = {u_reg, u_reg, u_reg};
        end
    end

    logic [2*mnsf_pkg::TS_W-1:0] tsx_prod;
    logic [2*mnsf_pkg::X_W-1:0]  sq_prod;
    logic [mnsf_pkg::S_W-1:0]    s_val;
    assign tsx_prod = ts_reg * cf_reg;
    assign sq_prod  = x_reg * x_reg;
    assign s_val    = sq_prod[mnsf_pkg::S_W+15:16];

    // divide by ten, one byte a step
    logic [11:0] v10;
    logic [24:0] v10_prod;
    logic [7:0]  qd10;
    logic [11:0] r10_full;
    assign v10      = {r10_reg, dsh_reg[mnsf_pkg::DV_W-1 -: 8]};
    assign v10_prod = v10 * mnsf_pkg::RECIP10;
    assign qd10     = v10_prod[23:16];
    assign r10_full = v10 - 12'(qd10) * 12'(mnsf_pkg::TEN);

    // coefficients
    logic signed [mnsf_pkg::CO_W-1:0] k_s, d_s, c_s;
    logic [mnsf_pkg::A2_W-1:0] a2_next;
    assign k_s = signed'(mnsf_pkg::CO_W'(kacc_reg[mnsf_pkg::K_W-1:0]));
    assign d_s = signed'(mnsf_pkg::CO_W'({x_reg, 9'b0}));
    assign c_s = signed'(mnsf_pkg::CO_W'(mnsf_pkg::C28));
    assign a2_next = mnsf_pkg::A2_W'(kacc_reg[mnsf_pkg::K_W-1:0])
                   + mnsf_pkg::A2_W'({x_reg, 9'b0}) + mnsf_pkg::C28;

    // shared multiplier: step pairs cover d*(u-u1), -a1*y1, -a0*y2, low slice then high
    logic signed [mnsf_pkg::CO_W-1:0] a_sel;
    logic signed [mnsf_pkg::B_W-1:0]  b_sel;
    logic signed [mnsf_pkg::LO_W:0]   mul_a;
    logic signed [mnsf_pkg::LO_W+mnsf_pkg::B_W:0] prod;
    logic signed [mnsf_pkg::ACC_W-1:0] term;
    always_comb begin
        case (cnt_reg[2:1])
            2'd0: begin
                a_sel = d_reg;
                b_sel = signed'(mnsf_pkg::B_W'($signed(u_reg)))
                      - signed'(mnsf_pkg::B_W'($signed(u1_reg)));
            end
            2'd1: begin
                a_sel = na1_reg;
                b_sel = signed'(mnsf_pkg::B_W'($signed(y1_reg)));
            end
            default: begin
                a_sel = na0_reg;
                b_sel = signed'(mnsf_pkg::B_W'($signed(y2_reg)));
            end
        endcase
        if (cnt_reg[0]) begin
            mul_a = (mnsf_pkg::LO_W+1)'($signed(a_sel[mnsf_pkg::CO_W-1:mnsf_pkg::LO_W]));
        end else begin
            mul_a = $signed({1'b0, a_sel[mnsf_pkg::LO_W-1:0]});
        end
        prod = mul_a * b_sel;
        term = cnt_reg[0] ? (mnsf_pkg::ACC_W'(prod) <<< mnsf_pkg::LO_W)
                          : mnsf_pkg::ACC_W'(prod);
    end

    // two restoring steps a cycle
    function automatic logic [mnsf_pkg::A2_W:0] div_step(
        input logic [mnsf_pkg::A2_W-1:0] rem,
        input logic                      b,
        input logic [mnsf_pkg::A2_W-1:0] dvs
    );
        logic [mnsf_pkg::A2_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, dvs}) begin
            t = t - {1'b0, dvs};
            return {1'b1, t[mnsf_pkg::A2_W-1:0]};
        end
        return {1'b0, t[mnsf_pkg::A2_W-1:0]};
    endfunction

    logic [mnsf_pkg::A2_W:0] st1, st2;
    assign st1 = div_step(rem_reg, qlo_reg[SW-1], a2_reg);
    assign st2 = div_step(st1[mnsf_pkg::A2_W-1:0], qlo_reg[SW-2], a2_reg);

    // final limit and sign
    logic          sat_next;
    logic [SW-1:0] qs, res_next;
    always_comb begin
        sat_next = big_reg || (neg_reg ? (q_reg[SW-1] && (q_reg[SW-2:0] != '0)) : q_reg[SW-1]);
        qs = q_reg;
        if (sat_next) begin
            qs = neg_reg ? mnsf_pkg::SAT_NEG : mnsf_pkg::SAT_POS;
        end
        res_next = neg_reg ? (SW'(0) - qs) : qs;
    end

    logic done_go;
    assign done_go   = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign ram_we    = done_go;
    assign ram_wdata = {y1_reg, res_next, u_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            ts_reg       <= mnsf_pkg::TS_RESET;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                ts_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        kind_reg  <= s_tuser;
                        idx_reg   <= s_tdata[AW-1:0];
                        u_reg     <= s_tdata[34:3];
                        cf_reg    <= s_tdata[58:35];
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    u1_reg    <= hist[SW-1:0];
                    y1_reg    <= hist[2*SW-1:SW];
                    y2_reg    <= hist[3*SW-1:2*SW];
                    x_reg     <= tsx_prod[mnsf_pkg::X_W+15:16];
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    dsh_reg   <= mnsf_pkg::DV_W'({s_val, 3'b0}) - mnsf_pkg::DV_W'(s_val);
                    kacc_reg  <= '0;
                    r10_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV10;
                end
                ST_DIV10: begin
                    kacc_reg <= {kacc_reg[mnsf_pkg::DV_W-9:0], qd10};
                    r10_reg  <= r10_full[3:0];
                    dsh_reg  <= {dsh_reg[mnsf_pkg::DV_W-9:0], 8'b0};
                    cnt_reg  <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(mnsf_pkg::DV_BYTES - 1)) begin
                        state_reg <= ST_COEF;
                    end
                end
                ST_COEF: begin
                    d_reg     <= d_s;
                    a2_reg    <= a2_next;
                    na1_reg   <= (c_s <<< 1) - (k_s <<< 1);
                    na0_reg   <= d_s - k_s - c_s;
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    acc_reg <= acc_reg + term;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd5) begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    neg_reg   <= acc_reg[mnsf_pkg::ACC_W-1];
                    mag_reg   <= acc_reg[mnsf_pkg::ACC_W-1] ? unsigned'(-acc_reg)
                                                            : unsigned'(acc_reg);
                    state_reg <= ST_RANGE;
                end
                ST_RANGE: begin
                    // quotient of 2^32 or more always clips
                    big_reg   <= mag_reg[mnsf_pkg::ACC_W-1:32]
                                 >= (mnsf_pkg::ACC_W-32)'(a2_reg);
                    rem_reg   <= mag_reg[32+mnsf_pkg::A2_W-1:32];
                    qlo_reg   <= mag_reg[SW-1:0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= st2[mnsf_pkg::A2_W-1:0];
                    q_reg   <= {q_reg[SW-3:0], st1[mnsf_pkg::A2_W], st2[mnsf_pkg::A2_W]};
                    qlo_reg <= {qlo_reg[SW-3:0], 2'b0};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (done_go) begin
                        m_tvalid_reg        <= 1'b1;
                        m_tdata_reg         <= res_next;
                        m_tuser_reg         <= sat_next;
                        valid_reg[idx_reg]  <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

[rtl/mnsf_checker.sv]
// Port-level checks for moving_notch_slope_filter_core, attached by bind.
// Depends on mnsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mnsf_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           cfg_we,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mnsf_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    // output register empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item at a time: no acceptance straight after an acceptance
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while busy");

    // a clipped item carries one of the two range limits
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
        (m_tdata == mnsf_pkg::SAT_POS || m_tdata == mnsf_pkg::SAT_NEG))
        else $error("saturated flag with value off the limits");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // time step only changes while no item is in work
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |-> s_tready)
        else $error("time step written while busy");

endmodule

bind moving_notch_slope_filter_core mnsf_checker u_mnsf_checker (.*);
`default_nettype wire
